/* rtl/core/aca_pkg.sv */
// Shared types and constants for the ADC channel averager.
package aca_pkg;

	localparam int SMP_W  = 10;        // width of a raw sample port
	localparam int SUM_W  = 15;        // width of a channel sum, wraps
	localparam int CNT_W  = 5;         // width of the sample count, wraps
	localparam int MEAN_W = 10;
	localparam int BATT_W = 9;
	localparam int N_CHAN = 4;         // pitch, roll, yaw, supply
	localparam int BATT_CHAN = 3;

	localparam int CLEAR_LIMIT_DEF = 30;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam logic [MEAN_W-1:0] MEAN_RST = MEAN_W'(512);
	localparam logic [MEAN_W-1:0] MEAN_MAX = MEAN_W'(1023);
	localparam logic [BATT_W-1:0] BATT_RST = BATT_W'(100);
	localparam logic [BATT_W-1:0] BATT_MAX = BATT_W'(511);

	// action codes on the input channel
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// battery scaling: (3*b + 11*v/30) / 4
	localparam int SCALE_W   = SUM_W + 4;  // holds 11*v
	localparam int SCALE_DIV = 30;

	typedef struct packed {
		logic load;       // sample transfer: latch sample, reset carry
		logic clear;      // zero the sum along with the load
		logic add_step;   // one bit of the serial add, LSB first
		logic div_start;  // read transfer: reset the remainder
		logic div_step;   // one quotient bit, MSB first
	} aca_lane_ctrl_t;

endpackage

/* rtl/core/adc_channel_averager.sv */
// Top level of the ADC channel averager: control sequencer, battery filter, output register.
//
// Input channel (in_valid/in_ready) carries action plus four raw 10-bit samples.
// action = 0 adds a sample set to the running sums; no result is produced.
// action = 1 reads: three gyro means and the filtered battery value appear on
// the output channel (out_valid/out_ready), with no_samples set when the read
// found an empty count, in which case the previous means and battery repeat.
//
// One item at a time; in_ready stays low until the work is done:
//   sample set: serial add after the transfer, one bit per cycle, then ready again
//   read:       serial division by the count in all four lanes, then 11*v is
//               formed and divided by 30 serially, then the output register is
//               loaded once it is free; the next transfer is taken after that
//   empty read: the done state follows the transfer and loads the output register
// The sum width sets the length of the add and the division, the width of 11*v that of the division by 30.
//
// Reset clears sums and count, sets the means to 512 and the battery to 100.
// A stalled receiver holds the result in the output register; sample sets are
// still taken meanwhile, but a further read finishes its work and then holds
// the block until the earlier result is taken.
module adc_channel_averager
	import aca_pkg::*;
#(
	parameter int CLEAR_LIMIT = CLEAR_LIMIT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [SMP_W-1:0]  pitch_sample,
	input  logic [SMP_W-1:0]  roll_sample,
	input  logic [SMP_W-1:0]  yaw_sample,
	input  logic [SMP_W-1:0]  supply_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MEAN_W-1:0] pitch_mean,
	output logic [MEAN_W-1:0] roll_mean,
	output logic [MEAN_W-1:0] yaw_mean,
	output logic [BATT_W-1:0] battery_tenths,
	output logic              no_samples
);

	localparam logic [SMP_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam int STEP_W = $clog2(SCALE_W + 1);
	localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(SUM_W - 1);
	localparam logic [STEP_W-1:0] SCALE_LAST = STEP_W'(SCALE_W);
	localparam logic [5:0]        SCALE_D    = 6'(SCALE_DIV);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   count_q;
	logic               empty_q;
	logic [SCALE_W-1:0] scl_q;
	logic [4:0]         rem30_q;
	logic               out_valid_q;
	logic [MEAN_W-1:0]  mean_q [3];
	logic [BATT_W-1:0]  batt_q;
	logic               no_samples_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               out_load;
	logic               clear_now;
	aca_lane_ctrl_t     lane_ctrl;
	logic [SMP_W-1:0]   lane_smp [N_CHAN];
	logic [SUM_W-1:0]   lane_acc [N_CHAN];
	logic [MEAN_W-1:0]  mean_sat [3];
	logic [SCALE_W-1:0] scaled;
	logic [5:0]         trial30;
	logic               ge30;
	logic [5:0]         diff30;
	logic [SCALE_W:0]   bsum;
	logic [SCALE_W-2:0] bnew;
	logic [BATT_W-1:0]  bnew_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign clear_now = (count_q == '0) || (count_q > CNT_W'(CLEAR_LIMIT));

	assign lane_ctrl.load      = in_xfer && (action == ACT_SAMPLE);
	assign lane_ctrl.clear     = clear_now;
	assign lane_ctrl.add_step  = (state_q == ST_ADD);
	assign lane_ctrl.div_start = in_xfer && (action == ACT_READ);
	assign lane_ctrl.div_step  = (state_q == ST_DIV);

	assign lane_smp[0] = pitch_sample  & SAMPLE_MASK;
	assign lane_smp[1] = roll_sample   & SAMPLE_MASK;
	assign lane_smp[2] = yaw_sample    & SAMPLE_MASK;
	assign lane_smp[3] = supply_sample & SAMPLE_MASK;

	for (genvar g = 0; g < N_CHAN; g++) begin : g_lane
		aca_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.sample  (lane_smp[g]),
			.divisor (count_q),
			.acc     (lane_acc[g])
		);
	end

	for (genvar g = 0; g < 3; g++) begin : g_sat
		assign mean_sat[g] = (lane_acc[g] > SUM_W'(MEAN_MAX)) ? MEAN_MAX
			: lane_acc[g][MEAN_W-1:0];
	end

	// 11*v = 8v + 2v + v
	assign scaled = SCALE_W'({lane_acc[BATT_CHAN], 3'b000})
		+ SCALE_W'({lane_acc[BATT_CHAN], 1'b0})
		+ SCALE_W'(lane_acc[BATT_CHAN]);

	assign trial30 = {rem30_q, scl_q[SCALE_W-1]};
	assign ge30    = trial30 >= SCALE_D;
	assign diff30  = trial30 - SCALE_D;

	assign bsum     = (SCALE_W+1)'({batt_q, 1'b0}) + (SCALE_W+1)'(batt_q)
		+ (SCALE_W+1)'(scl_q);
	assign bnew     = bsum[SCALE_W:2];
	assign bnew_sat = (bnew > (SCALE_W-1)'(BATT_MAX)) ? BATT_MAX : bnew[BATT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			count_q      <= '0;
			empty_q      <= 1'b0;
			scl_q        <= '0;
			rem30_q      <= '0;
			out_valid_q  <= 1'b0;
			mean_q[0]    <= MEAN_RST;
			mean_q[1]    <= MEAN_RST;
			mean_q[2]    <= MEAN_RST;
			batt_q       <= BATT_RST;
			no_samples_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_xfer) begin
						if (action == ACT_SAMPLE) begin
							count_q <= clear_now ? CNT_W'(1) : count_q + CNT_W'(1);
							state_q <= ST_ADD;
						end else begin
							empty_q <= (count_q == '0);
							state_q <= (count_q == '0) ? ST_DONE : ST_DIV;
						end
					end
				end
				ST_ADD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == DIV_LAST)
						state_q <= ST_IDLE;
				end
				ST_DIV: begin
					step_q <= (step_q == DIV_LAST) ? '0 : step_q + STEP_W'(1);
					if (step_q == DIV_LAST)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					// first cycle loads 11*v, the rest give one quotient bit each
					step_q <= step_q + STEP_W'(1);
					if (step_q == '0) begin
						scl_q   <= scaled;
						rem30_q <= '0;
					end else begin
						scl_q   <= {scl_q[SCALE_W-2:0], ge30};
						rem30_q <= ge30 ? diff30[4:0] : trial30[4:0];
						if (step_q == SCALE_LAST)
							state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						no_samples_q <= empty_q;
						if (!empty_q) begin
							mean_q[0] <= mean_sat[0];
							mean_q[1] <= mean_sat[1];
							mean_q[2] <= mean_sat[2];
							batt_q    <= bnew_sat;
							count_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign pitch_mean     = mean_q[0];
	assign roll_mean      = mean_q[1];
	assign yaw_mean       = mean_q[2];
	assign battery_tenths = batt_q;
	assign no_samples     = no_samples_q;

	// every transfer starts work that keeps the input from being taken again straight away
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken again straight after a transfer");

	// an empty read with a free output slot passes through the done state, then shows its flagged result
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && action == ACT_READ && count_q == '0 && !out_valid_q)
		|=> ##1 (out_valid && no_samples))
		else $error("empty read did not give a flagged result");

	// the count moves only on a transfer or when a read completes
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_xfer && state_q != ST_DONE) |=> $stable(count_q))
		else $error("sample count changed without cause");

endmodule

/* rtl/core/aca_lane.sv */
// One channel: bit-serial accumulator that turns into a bit-serial divider on a read.
module aca_lane
	import aca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  aca_lane_ctrl_t       ctrl,
	input  logic [SMP_W-1:0]     sample,
	input  logic [CNT_W-1:0]     divisor,
	output logic [SUM_W-1:0]     acc
);

	logic [SUM_W-1:0] sum_q;
	logic [SMP_W-1:0] smp_q;
	logic             carry_q;
	logic [CNT_W-1:0] rem_q;

	logic             add_bit;
	logic             add_carry;
	logic [CNT_W:0]   trial;
	logic             ge;
	logic [CNT_W:0]   diff;

	// add: sum rotates right, sample shifts out beneath it
	assign add_bit   = sum_q[0] ^ smp_q[0] ^ carry_q;
	assign add_carry = (sum_q[0] & smp_q[0]) | (sum_q[0] & carry_q) | (smp_q[0] & carry_q);

	// divide: dividend shifts left out of the sum, quotient bits fill in behind
	assign trial = {rem_q, sum_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.load && ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.add_step) begin
			sum_q <= {add_bit, sum_q[SUM_W-1:1]};
		end else if (ctrl.div_step) begin
			sum_q <= {sum_q[SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			smp_q   <= sample;
			carry_q <= 1'b0;
		end else if (ctrl.add_step) begin
			smp_q   <= {1'b0, smp_q[SMP_W-1:1]};
			carry_q <= add_carry;
		end
		if (ctrl.div_start) begin
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign acc = sum_q;

endmodule
